@@ hdl/ptp_pkg.sv @@
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared types and constants for the priority table with promote.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int PRI_W        = 16;
  localparam int ID_W         = 6;
  localparam int MODE_W       = 3;

  localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PROMOTE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEAD  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_LOOKUP,
    S_SCAN,
    S_SCAN_END,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              live;
    logic [PRI_W-1:0]  pri;
    logic [DATA_W-1:0] data;
  } row_t;

endpackage

@@ hdl/ptp_cmd_if.sv @@
// ----------------------------------------------------------------------------
// ptp_cmd_if
// Command channel: one beat carries one command.
// ----------------------------------------------------------------------------
interface ptp_cmd_if import ptp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   entry_id;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output mode, output entry_id, output data_in, input ready);
  modport sink (input valid, input mode, input entry_id, input data_in, output ready);
endinterface

@@ hdl/ptp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ptp_rsp_if
// Response channel: one beat per command.
// ----------------------------------------------------------------------------
interface ptp_rsp_if import ptp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ID_W-1:0]   id_out;
  logic [DATA_W-1:0] data_out;
  logic [PRI_W-1:0]  priority_out;
  logic              is_live;

  modport source (output valid, output status, output id_out, output data_out,
                  output priority_out, output is_live, input ready);
  modport sink (input valid, input status, input id_out, input data_out,
                input priority_out, input is_live, output ready);
endinterface

@@ hdl/ptp_store.sv @@
// ----------------------------------------------------------------------------
// ptp_store
// Entry table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptp_store import ptp_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output row_t          rd_row,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  row_t          wr_row
);

  row_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_row <= mem[rd_addr];
  end

endmodule

@@ hdl/priority_table_with_promote.sv @@
// ----------------------------------------------------------------------------
// priority_table_with_promote
// Indexed max-priority table with add, promote, pop/peek max and check.
// Add and unknown modes: the result is loaded in S_CMD.
// Promote and check: one table read in S_LOOKUP; promote then writes back.
// Pop and peek: one comparator walks the table one entry per cycle through
//   the single read port.
// One command at a time; a new command is taken the cycle after a result is
//   loaded, even while that result still waits. Reset clears control only.
// ----------------------------------------------------------------------------
module priority_table_with_promote import ptp_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  ptp_cmd_if.sink   cmd,
  ptp_rsp_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int CW = (NW > ID_W) ? NW : ID_W;

  state_t            state, state_next;
  logic [MODE_W-1:0] mode_q;
  logic [ID_W-1:0]   id_q;
  logic [DATA_W-1:0] data_q;
  logic [NW-1:0]     next_id, next_id_next;
  logic [AW-1:0]     cnt, cnt_next;
  logic [AW-1:0]     cmp_idx;
  logic              cmp_vld, cmp_vld_next;
  logic              found, found_clr;
  logic [AW-1:0]     best_idx;
  logic [PRI_W-1:0]  best_pri;
  logic [DATA_W-1:0] best_data;

  logic [AW-1:0]     rd_addr;
  row_t              rd_row;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  row_t              wr_row;

  logic              can_load, load;
  status_t           res_status;
  logic [ID_W-1:0]   res_id;
  logic [DATA_W-1:0] res_data;
  logic [PRI_W-1:0]  res_pri;
  logic              res_live;

  logic              id_in_range;
  logic [AW-1:0]     id_addr;
  logic [PRI_W-1:0]  pri_up;

  ptp_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row)
  );

  assign cmd.ready   = (state == S_IDLE);
  assign can_load    = !rsp.valid || rsp.ready;
  assign id_in_range = CW'(id_q) < CW'(next_id);
  assign id_addr     = AW'(id_q);
  assign pri_up      = (rd_row.pri == '1) ? rd_row.pri : rd_row.pri + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    next_id_next = next_id;
    cnt_next     = cnt;
    cmp_vld_next = 1'b0;
    found_clr    = 1'b0;
    rd_addr      = cnt;
    wr_en        = 1'b0;
    wr_addr      = AW'(next_id);
    wr_row       = '0;
    load         = 1'b0;
    res_status   = ST_OK;
    res_id       = '0;
    res_data     = '0;
    res_pri      = '0;
    res_live     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_CMD;
        end
      end
      S_CMD: begin
        case (mode_q)
          MODE_ADD: begin
            if (next_id == NW'(CAPACITY)) begin
              res_status = ST_FULL;
            end else begin
              res_id   = ID_W'(next_id);
              res_data = data_q;
              res_live = 1'b1;
            end
            if (can_load) begin
              load       = 1'b1;
              state_next = S_IDLE;
              if (next_id != NW'(CAPACITY)) begin
                wr_en        = 1'b1;
                wr_row.live  = 1'b1;
                wr_row.data  = data_q;
                next_id_next = next_id + 1'b1;
              end
            end
          end
          MODE_PROMOTE, MODE_CHECK: begin
            if (id_in_range) begin
              rd_addr    = id_addr;
              state_next = S_LOOKUP;
            end else begin
              res_status = ST_DEAD;
              res_id     = id_q;
              if (can_load) begin
                load       = 1'b1;
                state_next = S_IDLE;
              end
            end
          end
          MODE_POP, MODE_PEEK: begin
            if (next_id == '0) begin
              res_status = ST_EMPTY;
              if (can_load) begin
                load       = 1'b1;
                state_next = S_IDLE;
              end
            end else begin
              cnt_next   = '0;
              found_clr  = 1'b1;
              state_next = S_SCAN;
            end
          end
          default: begin
            if (can_load) begin
              load       = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_LOOKUP: begin
        rd_addr = id_addr;
        res_id  = id_q;
        if (!rd_row.live) begin
          res_status = ST_DEAD;
        end else begin
          res_data = rd_row.data;
          res_pri  = (mode_q == MODE_PROMOTE) ? pri_up : rd_row.pri;
          res_live = 1'b1;
        end
        if (can_load) begin
          load       = 1'b1;
          state_next = S_IDLE;
          if (rd_row.live && mode_q == MODE_PROMOTE) begin
            wr_en      = 1'b1;
            wr_addr    = id_addr;
            wr_row     = rd_row;
            wr_row.pri = pri_up;
          end
        end
      end
      S_SCAN: begin
        rd_addr      = cnt;
        cmp_vld_next = 1'b1;
        if (NW'(cnt) == next_id - 1'b1) begin
          state_next = S_SCAN_END;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SCAN_END: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!found) begin
          res_status = ST_EMPTY;
        end else begin
          res_id   = ID_W'(best_idx);
          res_data = best_data;
          res_pri  = best_pri;
          res_live = (mode_q == MODE_PEEK);
        end
        if (can_load) begin
          load       = 1'b1;
          state_next = S_IDLE;
          if (found && mode_q == MODE_POP) begin
            wr_en       = 1'b1;
            wr_addr     = best_idx;
            wr_row.live = 1'b0;
            wr_row.pri  = best_pri;
            wr_row.data = best_data;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      mode_q <= cmd.mode;
      id_q   <= cmd.entry_id;
      data_q <= cmd.data_in;
    end
    cnt     <= cnt_next;
    cmp_idx <= rd_addr;
    if (cmp_vld && rd_row.live && (!found || rd_row.pri >= best_pri)) begin
      best_idx  <= cmp_idx;
      best_pri  <= rd_row.pri;
      best_data <= rd_row.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= '0;
      cmp_vld <= 1'b0;
      found   <= 1'b0;
    end else begin
      next_id <= next_id_next;
      cmp_vld <= cmp_vld_next;
      if (found_clr) begin
        found <= 1'b0;
      end else if (cmp_vld && rd_row.live) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status       <= res_status;
      rsp.id_out       <= res_id;
      rsp.data_out     <= res_data;
      rsp.priority_out <= res_pri;
      rsp.is_live      <= res_live;
    end
  end

  a_next_id_bound: assert property (@(posedge clk) disable iff (rst)
    next_id <= NW'(CAPACITY))
    else $error("next_id beyond capacity");

  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> load)
    else $error("table written without a result");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("second command taken while busy");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (load && res_status == ST_FULL) |-> (next_id == NW'(CAPACITY)))
    else $error("full reported with free ids");

  a_pop_retires: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state == S_FINISH) |-> (!wr_row.live && found))
    else $error("pop write-back keeps entry live");

endmodule
